>>> src/elh_pkg.sv
// shared types, widths and the quarter-wave sine table of the hand length pipeline
package elh_pkg;

   localparam int AngleW = 9;
   localparam int AxisW  = 9;
   localparam int TrigW  = 17;
   localparam int RadW   = 64;
   localparam int RootW  = 32;
   localparam int SremW  = 33;
   localparam int NumW   = 39;
   localparam int QuoW   = 9;
   localparam int DremW  = 32;
   localparam int FracSh = 21;

   localparam logic [0:0] CsrWidth  = 1'b0;
   localparam logic [0:0] CsrHeight = 1'b1;

   localparam logic [AxisW-1:0] WidthReset  = 9'd144;
   localparam logic [AxisW-1:0] HeightReset = 9'd168;

   typedef struct packed {
      logic valid;
      logic short_hand;
   } tag_type;

   typedef struct packed {
      tag_type             tag;
      logic [SremW-1:0]    rem;
      logic [RootW-1:0]    root;
      logic [RadW-1:0]     rad;
   } sqrt_word_type;

   typedef struct packed {
      tag_type             tag;
      logic                sat;
      logic                zero;
      logic [DremW-1:0]    rem;
      logic [RootW-1:0]    root;
      logic [QuoW-1:0]     quo;
      logic [QuoW-1:0]     low;
   } div_word_type;

   typedef logic [TrigW-1:0] trig_tab_type [0:90];

   // round(65536 * sin(k degrees)), worked out at elaboration
   function automatic trig_tab_type make_sin_tab();
      trig_tab_type t;
      real          x;
      for (int k = 0; k <= 90; k++) begin
         x = 65536.0 * $sin(real'(k) * 3.14159265358979323846 / 180.0);
         t[k] = TrigW'($rtoi(x + 0.5));
      end
      return t;
   endfunction

   localparam trig_tab_type SinTab = make_sin_tab();

endpackage

>>> src/ellipse_hand_length.sv
// hand length from the ellipse polar radius, pipelined through root and divider cells
//
// channel  dir  word contents
// req_     in   tdata[8:0] angle_deg, tuser[0] short_hand
// rsp_     out  tdata[8:0] tip_y, tdata[18:9] base_y
// csr_     in   index 0 frame_width, index 1 frame_height
//
// one word per cycle unless a stalled result holds the pipeline; registers: 5 front stages, 32 root cells,
// 1 divider set-up, 9 divider cells and the output register.
// reset clears the valid bits and loads the axis defaults.
// a stalled result freezes the whole pipeline; req_tready follows that same enable.
module ellipse_hand_length (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // angle_deg
   input  logic [0:0]  req_tuser,   // short_hand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tip_y, base_y
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int Sqn = elh_pkg::RootW;
   localparam int Dvn = elh_pkg::QuoW;

   logic en;
   logic [elh_pkg::AxisW-1:0] width_ff, height_ff;

   elh_pkg::tag_type a_tag_ff, b_tag_ff, c_tag_ff, d_tag_ff;
   logic [elh_pkg::AngleW-1:0] a_ang_ff;
   logic [elh_pkg::TrigW-1:0] b_s_ff, b_c_ff;
   logic [25:0] c_as_ff, c_bc_ff;
   logic [51:0] d_sq1_ff, d_sq2_ff;

   logic [elh_pkg::AngleW-1:0] deg1, deg2, fold;

   elh_pkg::sqrt_word_type sq [0:Sqn];
   elh_pkg::div_word_type  dv [0:Dvn];
   elh_pkg::div_word_type  dv0_in;
   logic [elh_pkg::NumW-1:0] num;
   logic [17:0] ab;

   logic [7:0]  half;
   logic signed [9:0] len, len2, tip, base;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= elh_pkg::WidthReset;
         height_ff <= elh_pkg::HeightReset;
      end else if (csr_we) begin
         unique case (csr_index)
            elh_pkg::CsrWidth:  width_ff  <= csr_wdata;
            elh_pkg::CsrHeight: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fold the angle into the first quadrant
   always_comb begin
      deg1 = (a_ang_ff >= 9'd360) ? a_ang_ff - 9'd360 : a_ang_ff;
      deg2 = (deg1 >= 9'd180) ? deg1 - 9'd180 : deg1;
      fold = (deg2 > 9'd90) ? 9'd180 - deg2 : deg2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff.valid <= 1'b0;
         b_tag_ff.valid <= 1'b0;
         c_tag_ff.valid <= 1'b0;
         d_tag_ff.valid <= 1'b0;
      end else if (en) begin
         a_tag_ff <= '{valid: req_tvalid, short_hand: req_tuser[0]};
         a_ang_ff <= req_tdata[8:0];
         b_tag_ff <= a_tag_ff;
         b_s_ff   <= elh_pkg::SinTab[fold[6:0]];
         b_c_ff   <= elh_pkg::SinTab[7'(7'd90 - fold[6:0])];
         c_tag_ff <= b_tag_ff;
         c_as_ff  <= 26'(height_ff) * 26'(b_s_ff);
         c_bc_ff  <= 26'(width_ff) * 26'(b_c_ff);
         d_tag_ff <= c_tag_ff;
         d_sq1_ff <= c_as_ff * c_as_ff;
         d_sq2_ff <= c_bc_ff * c_bc_ff;
      end
   end

   // radicand register feeds the root chain; the sum stays below 2^51
   always_ff @(posedge clock) begin
      if (reset) begin
         sq[0].tag.valid <= 1'b0;
      end else if (en) begin
         sq[0].tag  <= d_tag_ff;
         sq[0].rem  <= '0;
         sq[0].root <= '0;
         sq[0].rad  <= {d_sq1_ff + d_sq2_ff, 12'd0};
      end
   end

   for (genvar i = 0; i < Sqn; i++) begin : g_sqrt
      elh_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (sq[i]),
         .d_out (sq[i+1])
      );
   end

   // divider set-up: numerator a*b*2^21, top part checked against the root
   always_comb begin
      ab            = height_ff * width_ff;
      num           = {ab, elh_pkg::FracSh'(0)};
      dv0_in.tag    = sq[Sqn].tag;
      dv0_in.root   = sq[Sqn].root;
      dv0_in.zero   = (sq[Sqn].root == '0);
      dv0_in.sat    = (elh_pkg::DremW'(num[elh_pkg::NumW-1:Dvn]) >= sq[Sqn].root);
      // a saturated word must not leave a wide remainder in the cells
      dv0_in.rem    = dv0_in.sat ? '0 : elh_pkg::DremW'(num[elh_pkg::NumW-1:Dvn]);
      dv0_in.quo    = '0;
      dv0_in.low    = num[Dvn-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv[0].tag.valid <= 1'b0;
      end else if (en) begin
         dv[0] <= dv0_in;
      end
   end

   for (genvar j = 0; j < Dvn; j++) begin : g_div
      elh_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (dv[j]),
         .d_out (dv[j+1])
      );
   end

   always_comb begin
      if (dv[Dvn].zero) begin
         half = 8'd0;
      end else if (dv[Dvn].sat || dv[Dvn].quo[Dvn-1]) begin
         half = 8'd255;
      end else begin
         half = dv[Dvn].quo[7:0];
      end
      len  = $signed({2'b00, half}) - 10'sd8;
      // halve toward zero
      len2 = dv[Dvn].tag.short_hand ? (len + $signed({9'd0, len < 0})) >>> 1 : len;
      tip  = -len2;
      base = (len2 >= 0) ? tip + 10'sd5 : tip - 10'sd5;
      rsp_data_in = {5'd0, base, tip[8:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv[Dvn].tag.valid;
      end
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> src/elh_sqrt_cell.sv
// one bit of the restoring square root chain
module elh_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  elh_pkg::sqrt_word_type d_in,
   output elh_pkg::sqrt_word_type d_out
);

   elh_pkg::sqrt_word_type word_ff;
   elh_pkg::sqrt_word_type word_in;
   logic [elh_pkg::SremW+1:0] remx;
   logic [elh_pkg::SremW+1:0] trial;

   always_comb begin
      remx  = {d_in.rem, d_in.rad[elh_pkg::RadW-1 -: 2]};
      trial = (elh_pkg::SremW+2)'({d_in.root, 2'b01});
      word_in     = d_in;
      word_in.rad = {d_in.rad[elh_pkg::RadW-3:0], 2'b00};
      if (remx >= trial) begin
         word_in.rem  = elh_pkg::SremW'(remx - trial);
         word_in.root = {d_in.root[elh_pkg::RootW-2:0], 1'b1};
      end else begin
         word_in.rem  = elh_pkg::SremW'(remx);
         word_in.root = {d_in.root[elh_pkg::RootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.tag.valid <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign d_out = word_ff;

endmodule

>>> src/elh_div_cell.sv
// one quotient bit of the restoring divider chain
module elh_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  elh_pkg::div_word_type d_in,
   output elh_pkg::div_word_type d_out
);

   elh_pkg::div_word_type word_ff;
   elh_pkg::div_word_type word_in;
   logic [elh_pkg::DremW:0] remx;

   always_comb begin
      remx        = {d_in.rem, d_in.low[elh_pkg::QuoW-1]};
      word_in     = d_in;
      word_in.low = {d_in.low[elh_pkg::QuoW-2:0], 1'b0};
      if (remx >= {1'b0, d_in.root}) begin
         word_in.rem = elh_pkg::DremW'(remx - {1'b0, d_in.root});
         word_in.quo = {d_in.quo[elh_pkg::QuoW-2:0], 1'b1};
      end else begin
         word_in.rem = elh_pkg::DremW'(remx);
         word_in.quo = {d_in.quo[elh_pkg::QuoW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.tag.valid <= 1'b0;
      end else if (en) begin
         word_ff <= word_in;
      end
   end

   assign d_out = word_ff;

endmodule
